FILE: hw/rtl/polar_to_cartesian_converter_macros.svh
// ----------------------------------------------------------------------------
// Polar to cartesian converter assertion macros
// Shared forms for the concurrent checks on the converter ports.
// ----------------------------------------------------------------------------
`ifndef POLAR_TO_CARTESIAN_CONVERTER_MACROS_SVH
`define POLAR_TO_CARTESIAN_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define P2C_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define P2C_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// Polar to cartesian converter package
// Constants, rotation angle table and link types shared by the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2c_pkg;

   // Fraction bits kept below the Q8.8 point inside the rotator.
   localparam int GUARD_BITS = 16;
   // Number of rotation cells.
   localparam int ROT_STEPS = 28;
   // Internal angle width: 2^32 units per turn.
   localparam int ANGLE_BITS = 32;
   // Inverse CORDIC gain, 0.607252935 in Q30.
   localparam int GAIN_BITS = 30;
   localparam logic [GAIN_BITS-1:0] GAIN_INV = 30'd652032874;
   localparam int PROD_SHIFT = GAIN_BITS - GUARD_BITS;
   // Stages from input to output: two prep stages, the cells, the output register.
   localparam int PIPE_DEPTH = ROT_STEPS + 3;

   typedef struct packed {
      logic valid;
      logic polar;
   } p2c_ctl_type;

   // atan(2^-step) in units of 2^-32 turn, truncated.
   function automatic logic [ANGLE_BITS-1:0] atan_turn(input int step);
      logic [ANGLE_BITS-1:0] val;
      case (step)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051D;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2E;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2F9;
         15: val = 32'h0000_517C;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A2F;
         19: val = 32'h0000_0517;
         20: val = 32'h0000_028B;
         21: val = 32'h0000_0145;
         22: val = 32'h0000_00A2;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0028;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/p2c_prep.sv
// ----------------------------------------------------------------------------
// Polar to cartesian converter front end
// Scales the radius by the inverse gain and folds the angle into the
// right half plane; cartesian items are aligned to the internal format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2c_prep
   import p2c_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16,
   parameter int SECOND_WIDTH = 16,
   parameter int DATA_WIDTH = 35
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                up_valid,
   input  wire                                up_polar,
   input  wire logic signed [COORD_WIDTH-1:0] up_first,
   input  wire logic [SECOND_WIDTH-1:0]       up_second,
   output logic                               up_ready,
   input  wire                                dn_ready,
   output p2c_ctl_type                        dn_ctl,
   output logic signed [DATA_WIDTH-1:0]       dn_x,
   output logic signed [DATA_WIDTH-1:0]       dn_y,
   output logic signed [ANGLE_BITS-1:0]       dn_z
);

   localparam int PROD_WIDTH = COORD_WIDTH + GAIN_BITS + 1;

   // Stage one: multiply and angle fold.
   p2c_ctl_type                    s1_ctl_ff;
   logic signed [PROD_WIDTH-1:0]   s1_prod_ff, s1_prod_in;
   logic signed [COORD_WIDTH-1:0]  s1_first_ff;
   logic [COORD_WIDTH-1:0]         s1_ybits_ff;
   logic                           s1_flip_ff, s1_flip_in;
   logic signed [ANGLE_BITS-1:0]   s1_z_ff, s1_z_in;
   logic                           s1_ready;
   logic [ANGLE_BITS-1:0]          angle_aligned;

   // Stage two: start vector.
   p2c_ctl_type                    s2_ctl_ff;
   logic signed [DATA_WIDTH-1:0]   s2_x_ff, s2_x_in;
   logic signed [DATA_WIDTH-1:0]   s2_y_ff, s2_y_in;
   logic signed [ANGLE_BITS-1:0]   s2_z_ff;
   logic                           s2_ready;
   logic signed [DATA_WIDTH-1:0]   x_scaled;

   assign s2_ready = !s2_ctl_ff.valid || dn_ready;
   assign s1_ready = !s1_ctl_ff.valid || s2_ready;
   assign up_ready = s1_ready;

   always_comb begin
      s1_prod_in = PROD_WIDTH'(up_first) * PROD_WIDTH'($signed({1'b0, GAIN_INV}));
      angle_aligned = ANGLE_BITS'(up_second[ANGLE_WIDTH-1:0]) << (ANGLE_BITS - ANGLE_WIDTH);
      // The second and third quarter turns are folded by half a turn and a
      // negated start vector.
      s1_flip_in = angle_aligned[ANGLE_BITS-1] ^ angle_aligned[ANGLE_BITS-2];
      if (s1_flip_in) begin
         s1_z_in = $signed({~angle_aligned[ANGLE_BITS-1], angle_aligned[ANGLE_BITS-2:0]});
      end else begin
         s1_z_in = $signed(angle_aligned);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (s1_ready) begin
         s1_ctl_ff.valid <= up_valid;
         s1_ctl_ff.polar <= up_polar;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_prod_ff  <= s1_prod_in;
         s1_first_ff <= up_first;
         s1_ybits_ff <= up_second[COORD_WIDTH-1:0];
         s1_flip_ff  <= s1_flip_in;
         s1_z_ff     <= s1_z_in;
      end
   end

   always_comb begin
      x_scaled = DATA_WIDTH'(s1_prod_ff >>> PROD_SHIFT);
      if (s1_ctl_ff.polar) begin
         s2_x_in = s1_flip_ff ? -x_scaled : x_scaled;
         s2_y_in = '0;
      end else begin
         // Cartesian values ride through the cells untouched and come out
         // exactly after rounding.
         s2_x_in = DATA_WIDTH'(s1_first_ff) <<< GUARD_BITS;
         s2_y_in = DATA_WIDTH'($signed(s1_ybits_ff)) <<< GUARD_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (s2_ready) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_x_ff <= s2_x_in;
         s2_y_ff <= s2_y_in;
         s2_z_ff <= s1_z_ff;
      end
   end

   assign dn_ctl = s2_ctl_ff;
   assign dn_x   = s2_x_ff;
   assign dn_y   = s2_y_ff;
   assign dn_z   = s2_z_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/p2c_cell.sv
// ----------------------------------------------------------------------------
// Polar to cartesian converter rotation cell
// One CORDIC micro-rotation by atan(2^-STEP), registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2c_cell
   import p2c_pkg::*;
#(
   parameter int STEP = 0,
   parameter int DATA_WIDTH = 35
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire p2c_ctl_type                   up_ctl,
   input  wire logic signed [DATA_WIDTH-1:0]  up_x,
   input  wire logic signed [DATA_WIDTH-1:0]  up_y,
   input  wire logic signed [ANGLE_BITS-1:0]  up_z,
   output logic                               up_ready,
   input  wire                                dn_ready,
   output p2c_ctl_type                        dn_ctl,
   output logic signed [DATA_WIDTH-1:0]       dn_x,
   output logic signed [DATA_WIDTH-1:0]       dn_y,
   output logic signed [ANGLE_BITS-1:0]       dn_z
);

   localparam logic signed [ANGLE_BITS-1:0] ATAN_STEP = $signed(atan_turn(STEP));

   p2c_ctl_type                   ctl_ff;
   logic signed [DATA_WIDTH-1:0]  x_ff, x_in;
   logic signed [DATA_WIDTH-1:0]  y_ff, y_in;
   logic signed [ANGLE_BITS-1:0]  z_ff, z_in;
   logic signed [DATA_WIDTH-1:0]  x_sh, y_sh;

   assign up_ready = !ctl_ff.valid || dn_ready;

   always_comb begin
      x_sh = up_x >>> STEP;
      y_sh = up_y >>> STEP;
      if (!up_ctl.polar) begin
         x_in = up_x;
         y_in = up_y;
         z_in = up_z;
      end else if (!up_z[ANGLE_BITS-1]) begin
         x_in = up_x - y_sh;
         y_in = up_y + x_sh;
         z_in = up_z - ATAN_STEP;
      end else begin
         x_in = up_x + y_sh;
         y_in = up_y - x_sh;
         z_in = up_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (up_ready) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/polar_to_cartesian_converter.sv
// ----------------------------------------------------------------------------
// Polar to cartesian converter
// Q8.8 polar to rectangular conversion through a pipelined CORDIC rotator.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel yields exactly one transfer on the rsp_
// channel, in order. Polar items (req_type high) give x = r*cos(theta) and
// y = r*sin(theta), rounded and saturated; cartesian items come back
// unchanged. The block takes one item per cycle while req_stall is low; an
// item passes two front-end stages (gain multiply and angle fold, start
// vector), 28 rotation cells, and the output register. A stall on rsp_ only
// holds the stages that are full, so empty slots in the chain are squeezed
// out and req_stall rises only when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module polar_to_cartesian_converter
   import p2c_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16,
   localparam int SECOND_WIDTH = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_type,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_value,
   input  wire logic [SECOND_WIDTH-1:0]       req_second_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_x_coord,
   output logic signed [COORD_WIDTH-1:0]      rsp_y_coord
);

   // Room for the gain overshoot of the rotation and the fraction guard bits.
   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
   localparam int Q_WIDTH = DATA_WIDTH - GUARD_BITS;
   localparam logic signed [DATA_WIDTH-1:0] ROUND_HALF =
      DATA_WIDTH'(1) <<< (GUARD_BITS - 1);

   p2c_ctl_type                   link_ctl   [ROT_STEPS+1];
   logic signed [DATA_WIDTH-1:0]  link_x     [ROT_STEPS+1];
   logic signed [DATA_WIDTH-1:0]  link_y     [ROT_STEPS+1];
   logic signed [ANGLE_BITS-1:0]  link_z     [ROT_STEPS+1];
   logic                          link_ready [ROT_STEPS+1];
   logic                          in_ready;

   logic                          rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] x_coord_ff, x_coord_in;
   logic signed [COORD_WIDTH-1:0] y_coord_ff, y_coord_in;
   logic                          out_ready;

   function automatic logic signed [COORD_WIDTH-1:0] round_sat(
      input logic signed [DATA_WIDTH-1:0] v
   );
      logic signed [DATA_WIDTH-1:0] sum;
      logic signed [Q_WIDTH-1:0]    q;
      logic signed [COORD_WIDTH-1:0] res;
      sum = v + ROUND_HALF;
      q   = sum[DATA_WIDTH-1:GUARD_BITS];
      // In range when all bits above the result's sign bit agree with it.
      if ((&q[Q_WIDTH-1:COORD_WIDTH-1]) || !(|q[Q_WIDTH-1:COORD_WIDTH-1])) begin
         res = q[COORD_WIDTH-1:0];
      end else if (q[Q_WIDTH-1]) begin
         res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   p2c_prep #(
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .SECOND_WIDTH (SECOND_WIDTH),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (req_valid),
      .up_polar  (req_type),
      .up_first  (req_first_value),
      .up_second (req_second_value),
      .up_ready  (in_ready),
      .dn_ready  (link_ready[0]),
      .dn_ctl    (link_ctl[0]),
      .dn_x      (link_x[0]),
      .dn_y      (link_y[0]),
      .dn_z      (link_z[0])
   );

   assign req_stall = !in_ready;

   for (genvar g = 0; g < ROT_STEPS; g++) begin : g_cell
      p2c_cell #(
         .STEP       (g),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (link_ctl[g]),
         .up_x     (link_x[g]),
         .up_y     (link_y[g]),
         .up_z     (link_z[g]),
         .up_ready (link_ready[g]),
         .dn_ready (link_ready[g+1]),
         .dn_ctl   (link_ctl[g+1]),
         .dn_x     (link_x[g+1]),
         .dn_y     (link_y[g+1]),
         .dn_z     (link_z[g+1])
      );
   end

   // The final angle residue is not needed.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign link_ready[ROT_STEPS] = out_ready;

   always_comb begin
      x_coord_in = round_sat(link_x[ROT_STEPS]);
      y_coord_in = round_sat(link_y[ROT_STEPS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= link_ctl[ROT_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         x_coord_ff <= x_coord_in;
         y_coord_ff <= y_coord_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_coord = x_coord_ff;
   assign rsp_y_coord = y_coord_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/p2c_checker.sv
// ----------------------------------------------------------------------------
// Polar to cartesian converter checker
// Port-level checks on transfer ordering and occupancy of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "polar_to_cartesian_converter_macros.svh"

module p2c_checker
   import p2c_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire logic signed [COORD_WIDTH-1:0] rsp_x_coord,
   input wire logic signed [COORD_WIDTH-1:0] rsp_y_coord
);

   localparam int COUNT_WIDTH = $clog2(PIPE_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = COUNT_WIDTH'(PIPE_DEPTH);

   // Items taken in but not yet handed out, as seen on the ports.
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   in_xfer, out_xfer;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (in_xfer && !out_xfer) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (out_xfer && !in_xfer) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `P2C_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_x_coord) && $stable(rsp_y_coord),
      "stalled result changed")
   `P2C_ASSERT_SAME(a_rsp_has_item, rsp_valid, count_ff != '0,
      "result shown with no item outstanding")
   `P2C_ASSERT_SAME(a_no_stall_when_empty, !rsp_valid, !req_stall,
      "input stalled while the output register is empty")
   `P2C_ASSERT_SAME(a_depth_bound, 1'b1, count_ff <= MAX_COUNT,
      "more items outstanding than pipeline stages")

endmodule

bind polar_to_cartesian_converter p2c_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_p2c_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_x_coord (rsp_x_coord),
   .rsp_y_coord (rsp_y_coord)
);

`default_nettype wire
